// ===== sv/iba_pkg.sv =====
// Package for the I2C address probe: word types, configuration register
// indexes, the probe phase encoding and the tick delay compare.
// No dependencies.
package iba_pkg;

  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned CfgDataWidth  = 16;

  localparam logic [CfgIndexWidth-1:0] CfgHalfPeriod   = 2'd0;
  localparam logic [CfgIndexWidth-1:0] CfgStretchLimit = 2'd1;
  localparam logic [CfgIndexWidth-1:0] CfgSettle       = 2'd2;

  localparam logic [15:0] HalfPeriodReset   = 16'd5;
  localparam logic [15:0] StretchLimitReset = 16'd100;
  localparam logic [7:0]  SettleReset       = 8'd5;

  localparam logic [3:0] BitsPerByte = 4'd8;

  typedef enum logic [0:0] {
    FuncTick  = 1'b0,
    FuncStart = 1'b1
  } func_e;

  typedef struct packed {
    logic       func;
    logic [6:0] target_address;
    logic       scl_level;
    logic       sda_level;
  } in_item_t;

  typedef struct packed {
    logic scl_release;
    logic sda_release;
    logic busy_res;
    logic done_res;
    logic ack_seen;
  } out_item_t;

  typedef struct packed {
    logic [15:0] half_period_ticks;
    logic [15:0] stretch_limit_ticks;
    logic [7:0]  settle_ticks;
  } cfg_t;

  typedef enum logic [15:0] {
    PhIdle     = 16'h0001,
    PhStartPre = 16'h0002,
    PhStartStr = 16'h0004,
    PhStartHld = 16'h0008,
    PhStartLow = 16'h0010,
    PhBitSetup = 16'h0020,
    PhBitHigh  = 16'h0040,
    PhBitStr   = 16'h0080,
    PhBitSettl = 16'h0100,
    PhAckSetup = 16'h0200,
    PhAckStr   = 16'h0400,
    PhAckHigh  = 16'h0800,
    PhStop1    = 16'h1000,
    PhStop2    = 16'h2000,
    PhStop3    = 16'h3000 ^ 16'h7000,
    PhStop4    = 16'h8000
  } phase_e;

  // True when a delay of n ticks ends on this tick, given the ticks counted.
  function automatic logic delay_over(logic [15:0] count, logic [15:0] n);
    logic [16:0] next_count;
    next_count = {1'b0, count} + 17'd1;
    return next_count >= {1'b0, n};
  endfunction

endpackage

// ===== sv/i2c_bitbang_address_probe.sv =====
// Top level of the I2C address probe: input word register, sequencer,
// configuration registers and result word register.
// Depends on iba_pkg, iba_cfg and iba_seq.
//
//   Channel   Direction  Handshake                  Word
//   in        to block   in_valid_i / in_stall_o    iba_pkg::in_item_t
//   out       from block out_valid_o / out_stall_i  iba_pkg::out_item_t
//   cfg       to block   cfg_we_i                   cfg_index_i, cfg_data_i
//
// The sequencer steps once per accepted word; one word is accepted per cycle while
// the input is not stalled. An accepted word is held in the input register, and its
// result word is registered in the result register when the sequencer steps.
// The sequencer steps when its input register holds a word and the result
// register is empty or being taken; a held word that cannot step stalls the input.
// Reset leaves the probe idle with both lines released and the config defaults.
module i2c_bitbang_address_probe (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  iba_pkg::in_item_t                 in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output iba_pkg::out_item_t                out_data_o,
  input  logic                              cfg_we_i,
  input  logic [iba_pkg::CfgIndexWidth-1:0] cfg_index_i,
  input  logic [iba_pkg::CfgDataWidth-1:0]  cfg_data_i
);

  logic               in_valid_q;
  iba_pkg::in_item_t  in_data_q;
  logic               out_valid_q;
  iba_pkg::out_item_t out_data_q;
  logic               advance;
  iba_pkg::cfg_t      cfg;
  iba_pkg::out_item_t res;

  assign advance    = in_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = in_valid_q & out_valid_q & out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_data_q <= in_data_i;
    end
  end

  iba_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  iba_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .item_i (in_data_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== sv/iba_cfg.sv =====
// Configuration registers of the I2C address probe.
// Depends on iba_pkg.
module iba_cfg (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [iba_pkg::CfgIndexWidth-1:0]    cfg_index_i,
  input  logic [iba_pkg::CfgDataWidth-1:0]     cfg_data_i,
  output iba_pkg::cfg_t                        cfg_o
);

  logic [15:0] half_period_q;
  logic [15:0] stretch_limit_q;
  logic [7:0]  settle_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_period_q   <= iba_pkg::HalfPeriodReset;
      stretch_limit_q <= iba_pkg::StretchLimitReset;
      settle_q        <= iba_pkg::SettleReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        iba_pkg::CfgHalfPeriod:   half_period_q   <= cfg_data_i;
        iba_pkg::CfgStretchLimit: stretch_limit_q <= cfg_data_i;
        iba_pkg::CfgSettle:       settle_q        <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign cfg_o.half_period_ticks   = half_period_q;
  assign cfg_o.stretch_limit_ticks = stretch_limit_q;
  assign cfg_o.settle_ticks        = settle_q;

endmodule

// ===== sv/iba_seq.sv =====
// Probe sequencer: phase, delay counter, address shifter and line drives,
// advanced by one word per enabled cycle. Depends on iba_pkg.
module iba_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  iba_pkg::in_item_t  item_i,
  input  iba_pkg::cfg_t      cfg_i,
  output iba_pkg::out_item_t res_o
);

  iba_pkg::phase_e phase_q, phase_d;
  logic [15:0] wait_q, wait_d;
  logic [3:0]  bit_index_q, bit_index_d;
  logic [7:0]  shift_q, shift_d;
  logic        ack_q, ack_d;
  logic        scl_q, scl_d;
  logic        sda_q, sda_d;
  logic        done;

  logic [15:0] wait_inc;
  logic        hp_over;
  logic        settle_over;
  logic        stretch_over;
  logic [3:0]  bit_next;
  logic [7:0]  shift_next;

  assign wait_inc     = wait_q + 16'd1;
  assign hp_over      = iba_pkg::delay_over(wait_q, cfg_i.half_period_ticks);
  assign settle_over  = iba_pkg::delay_over(wait_q, {8'd0, cfg_i.settle_ticks});
  assign stretch_over = iba_pkg::delay_over(wait_q, cfg_i.stretch_limit_ticks);
  assign bit_next     = bit_index_q + 4'd1;
  assign shift_next   = {shift_q[6:0], 1'b0};

  always_comb begin
    phase_d     = phase_q;
    wait_d      = wait_q;
    bit_index_d = bit_index_q;
    shift_d     = shift_q;
    ack_d       = ack_q;
    scl_d       = scl_q;
    sda_d       = sda_q;
    done        = 1'b0;

    if (item_i.func == iba_pkg::FuncStart) begin
      if (phase_q == iba_pkg::PhIdle) begin
        shift_d     = {item_i.target_address, 1'b0};
        bit_index_d = 4'd0;
        ack_d       = 1'b0;
        scl_d       = 1'b1;
        sda_d       = 1'b1;
        phase_d     = iba_pkg::PhStartPre;
        wait_d      = 16'd0;
      end
    end else begin
      unique case (phase_q)
        iba_pkg::PhIdle: ;
        iba_pkg::PhStartPre: begin
          wait_d = hp_over ? 16'd0 : wait_inc;
          if (hp_over) begin
            scl_d   = 1'b1;
            phase_d = iba_pkg::PhStartStr;
          end
        end
        iba_pkg::PhStartStr: begin
          if (item_i.scl_level) begin
            wait_d  = 16'd0;
            sda_d   = 1'b0;
            phase_d = iba_pkg::PhStartHld;
          end else if (stretch_over) begin
            wait_d  = 16'd0;
            phase_d = iba_pkg::PhStop1;
          end else begin
            wait_d = wait_inc;
          end
        end
        iba_pkg::PhStartHld: begin
          wait_d = hp_over ? 16'd0 : wait_inc;
          if (hp_over) begin
            scl_d   = 1'b0;
            phase_d = iba_pkg::PhStartLow;
          end
        end
        iba_pkg::PhStartLow: begin
          wait_d = hp_over ? 16'd0 : wait_inc;
          if (hp_over) begin
            sda_d   = shift_q[7];
            phase_d = iba_pkg::PhBitSetup;
          end
        end
        iba_pkg::PhBitSetup: begin
          wait_d = hp_over ? 16'd0 : wait_inc;
          if (hp_over) begin
            scl_d   = 1'b1;
            phase_d = iba_pkg::PhBitHigh;
          end
        end
        iba_pkg::PhBitHigh: begin
          wait_d = hp_over ? 16'd0 : wait_inc;
          if (hp_over) begin
            phase_d = iba_pkg::PhBitStr;
          end
        end
        iba_pkg::PhBitStr: begin
          if (item_i.scl_level) begin
            wait_d  = 16'd0;
            scl_d   = 1'b0;
            phase_d = iba_pkg::PhBitSettl;
          end else if (stretch_over) begin
            wait_d  = 16'd0;
            phase_d = iba_pkg::PhStop1;
          end else begin
            wait_d = wait_inc;
          end
        end
        iba_pkg::PhBitSettl: begin
          wait_d = settle_over ? 16'd0 : wait_inc;
          if (settle_over) begin
            bit_index_d = bit_next;
            shift_d     = shift_next;
            if (bit_next >= iba_pkg::BitsPerByte) begin
              sda_d   = 1'b1;
              phase_d = iba_pkg::PhAckSetup;
            end else begin
              sda_d   = shift_next[7];
              phase_d = iba_pkg::PhBitSetup;
            end
          end
        end
        iba_pkg::PhAckSetup: begin
          wait_d = hp_over ? 16'd0 : wait_inc;
          if (hp_over) begin
            scl_d   = 1'b1;
            phase_d = iba_pkg::PhAckStr;
          end
        end
        iba_pkg::PhAckStr: begin
          if (item_i.scl_level) begin
            wait_d  = 16'd0;
            ack_d   = ~item_i.sda_level;
            phase_d = iba_pkg::PhAckHigh;
          end else if (stretch_over) begin
            wait_d  = 16'd0;
            phase_d = iba_pkg::PhStop1;
          end else begin
            wait_d = wait_inc;
          end
        end
        iba_pkg::PhAckHigh: begin
          wait_d = hp_over ? 16'd0 : wait_inc;
          if (hp_over) begin
            scl_d   = 1'b0;
            phase_d = iba_pkg::PhStop1;
          end
        end
        iba_pkg::PhStop1: begin
          wait_d = hp_over ? 16'd0 : wait_inc;
          if (hp_over) begin
            sda_d   = 1'b0;
            phase_d = iba_pkg::PhStop2;
          end
        end
        iba_pkg::PhStop2: begin
          wait_d = hp_over ? 16'd0 : wait_inc;
          if (hp_over) begin
            scl_d   = 1'b1;
            phase_d = iba_pkg::PhStop3;
          end
        end
        iba_pkg::PhStop3: begin
          wait_d = hp_over ? 16'd0 : wait_inc;
          if (hp_over) begin
            sda_d   = 1'b1;
            phase_d = iba_pkg::PhStop4;
          end
        end
        iba_pkg::PhStop4: begin
          wait_d = hp_over ? 16'd0 : wait_inc;
          if (hp_over) begin
            phase_d = iba_pkg::PhIdle;
            done    = 1'b1;
          end
        end
        default: begin
          phase_d = iba_pkg::PhIdle;
          wait_d  = 16'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= iba_pkg::PhIdle;
      wait_q      <= 16'd0;
      bit_index_q <= 4'd0;
      shift_q     <= 8'd0;
      ack_q       <= 1'b0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
    end else if (en_i) begin
      phase_q     <= phase_d;
      wait_q      <= wait_d;
      bit_index_q <= bit_index_d;
      shift_q     <= shift_d;
      ack_q       <= ack_d;
      scl_q       <= scl_d;
      sda_q       <= sda_d;
    end
  end

  assign res_o.scl_release = scl_d;
  assign res_o.sda_release = sda_d;
  assign res_o.busy_res    = (phase_d != iba_pkg::PhIdle);
  assign res_o.done_res    = done;
  assign res_o.ack_seen    = ack_d;

endmodule
